FILE: sv/skvt_pkg.sv
// Shared types, codes and compare functions for the sorted keyed value table.
package skvt_pkg;

  localparam int unsigned CAPACITY = 64;

  localparam int unsigned CodeW  = 16;
  localparam int unsigned WordW  = 32;
  localparam int unsigned StatW  = 3;
  localparam int unsigned TotalW = 7;

  localparam logic REQ_SET  = 1'b0;
  localparam logic REQ_FIND = 1'b1;

  localparam logic [StatW-1:0] STATUS_REPLACED  = 3'd0;
  localparam logic [StatW-1:0] STATUS_INSERTED  = 3'd1;
  localparam logic [StatW-1:0] STATUS_FOUND     = 3'd2;
  localparam logic [StatW-1:0] STATUS_NOT_FOUND = 3'd3;
  localparam logic [StatW-1:0] STATUS_FULL      = 3'd4;

  typedef struct packed {
    logic [CodeW-1:0]        code;
    logic signed [WordW-1:0] product;
    logic signed [WordW-1:0] first_param;
    logic signed [WordW-1:0] second_param;
  } key_t;

  typedef struct packed {
    logic cmp;
    logic scan;
    logic replace;
    logic insert;
  } cell_ctrl_t;

  typedef struct packed {
    key_t             key;
    logic [WordW-1:0] value;
    logic             lt;
    logic             hit;
    logic [WordW-1:0] acc;
  } cell_link_t;

  function automatic logic key_equal(key_t a, key_t b);
    return (a.code == b.code) && (a.product == b.product) &&
           (a.first_param == b.first_param) && (a.second_param == b.second_param);
  endfunction

  function automatic logic key_less(key_t a, key_t b);
    logic res;
    if (a.code != b.code) begin
      res = a.code < b.code;
    end else if (a.product != b.product) begin
      res = $signed(a.product) < $signed(b.product);
    end else if (a.first_param != b.first_param) begin
      res = $signed(a.first_param) < $signed(b.first_param);
    end else begin
      res = $signed(a.second_param) < $signed(b.second_param);
    end
    return res;
  endfunction

endpackage

FILE: sv/skvt_req_if.sv
// Request channel: valid/ready handshake with set/find payload.
interface skvt_req_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [skvt_pkg::CodeW-1:0]        key_code;
  logic signed [skvt_pkg::WordW-1:0] key_product;
  logic signed [skvt_pkg::WordW-1:0] key_first_param;
  logic signed [skvt_pkg::WordW-1:0] key_second_param;
  logic [skvt_pkg::WordW-1:0]        entry_value;

  modport source (
    output valid, req_type, key_code, key_product, key_first_param, key_second_param,
           entry_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, key_code, key_product, key_first_param, key_second_param,
           entry_value,
    output ready
  );
endinterface

FILE: sv/skvt_rsp_if.sv
// Response channel: valid/ready handshake with status payload.
interface skvt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [skvt_pkg::StatW-1:0]  status;
  logic [skvt_pkg::WordW-1:0]  found_value;
  logic [skvt_pkg::TotalW-1:0] entry_total;

  modport source (
    output valid, status, found_value, entry_total,
    input  ready
  );
  modport sink (
    input  valid, status, found_value, entry_total,
    output ready
  );
endinterface

FILE: sv/skvt_cell.sv
// One table cell: holds an entry, compares it with the request and links to its neighbor.
module skvt_cell #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned CntW = 7
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  skvt_pkg::cell_ctrl_t       ctrl_i,
  input  skvt_pkg::key_t             req_key_i,
  input  logic [skvt_pkg::WordW-1:0] req_value_i,
  input  logic [CntW-1:0]            count_i,
  input  skvt_pkg::cell_link_t       prev_i,
  output skvt_pkg::cell_link_t       link_o
);

  skvt_pkg::key_t             key_q;
  logic [skvt_pkg::WordW-1:0] value_q;
  logic                       lt_q;
  logic                       eq_q;
  logic                       hit_q;
  logic [skvt_pkg::WordW-1:0] acc_q;
  logic                       occupied;
  logic                       eq_now;

  assign occupied = CntW'(IDX) < count_i;
  assign eq_now   = occupied && skvt_pkg::key_equal(key_q, req_key_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q  <= 1'b0;
      eq_q  <= 1'b0;
      hit_q <= 1'b0;
      acc_q <= '0;
    end else if (ctrl_i.cmp) begin
      lt_q  <= occupied && skvt_pkg::key_less(key_q, req_key_i);
      eq_q  <= eq_now;
      hit_q <= eq_now;
      acc_q <= eq_now ? value_q : '0;
    end else if (ctrl_i.scan) begin
      hit_q <= hit_q | prev_i.hit;
      acc_q <= acc_q | prev_i.acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.replace && eq_q) begin
      value_q <= req_value_i;
    end else if (ctrl_i.insert && !lt_q) begin
      if (prev_i.lt) begin
        key_q   <= req_key_i;
        value_q <= req_value_i;
      end else begin
        key_q   <= prev_i.key;
        value_q <= prev_i.value;
      end
    end
  end

  assign link_o.key   = key_q;
  assign link_o.value = value_q;
  assign link_o.lt    = lt_q;
  assign link_o.hit   = hit_q;
  assign link_o.acc   = acc_q;

endmodule

FILE: sv/sorted_keyed_value_table_core.sv
// Top level of the sorted keyed value table: request control and the chain of cells.
//
//   channel | dir | handshake     | payload
//   req_i   | in  | valid / ready | req_type, key_code, key_product, key_first_param,
//           |     |               | key_second_param, entry_value
//   rsp_o   | out | valid / ready | status, found_value, entry_total
//
// Each request passes through these steps in order: take the transfer, compare every cell
// with the key, pass the hit flag and value down the cell chain, and apply; the response is
// registered in the apply step.
// One request is in work at a time; the next is taken while a response waits.
// Reset empties the table at once (entry count to zero); no clearing pass.
// A stalled response holds the apply step until the response register is free.
module sorted_keyed_value_table_core #(
  parameter int unsigned CAPACITY = skvt_pkg::CAPACITY
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  skvt_req_if.sink   req_i,
  skvt_rsp_if.source rsp_o
);

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned ScanW = $clog2(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_SCAN,
    ST_APPLY
  } state_e;

  state_e                          state_q;
  logic                            type_q;
  skvt_pkg::key_t                  key_q;
  logic [skvt_pkg::WordW-1:0]      value_q;
  logic [CntW-1:0]                 count_q;
  logic [ScanW-1:0]                scan_q;
  logic                            out_valid_q;
  logic [skvt_pkg::StatW-1:0]      out_status_q;
  logic [skvt_pkg::WordW-1:0]      out_value_q;
  logic [skvt_pkg::TotalW-1:0]     out_total_q;

  skvt_pkg::cell_ctrl_t            ctrl;
  skvt_pkg::cell_link_t            chain [0:CAPACITY];
  logic                            out_free;
  logic                            hit;
  logic                            full;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign hit      = chain[CAPACITY].hit;
  assign full     = count_q == CntW'(CAPACITY);

  always_comb begin
    ctrl.cmp     = state_q == ST_CMP;
    ctrl.scan    = state_q == ST_SCAN;
    ctrl.replace = (state_q == ST_APPLY) && out_free && (type_q == skvt_pkg::REQ_SET) && hit;
    ctrl.insert  = (state_q == ST_APPLY) && out_free && (type_q == skvt_pkg::REQ_SET) &&
                   !hit && !full;
  end

  assign chain[0].key   = '0;
  assign chain[0].value = '0;
  assign chain[0].lt    = 1'b1;
  assign chain[0].hit   = 1'b0;
  assign chain[0].acc   = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    skvt_cell #(
      .IDX  (i),
      .CntW (CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .req_key_i   (key_q),
      .req_value_i (value_q),
      .count_i     (count_q),
      .prev_i      (chain[i]),
      .link_o      (chain[i+1])
    );
  end

  assign req_i.ready       = state_q == ST_IDLE;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.found_value = out_value_q;
  assign rsp_o.entry_total = out_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_APPLY) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            state_q <= ST_CMP;
          end
        end
        ST_CMP: begin
          scan_q  <= '0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_q == ScanW'(CAPACITY - 2)) begin
            state_q <= ST_APPLY;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        ST_APPLY: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (ctrl.insert) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      type_q             <= req_i.req_type;
      key_q.code         <= req_i.key_code;
      key_q.product      <= req_i.key_product;
      key_q.first_param  <= req_i.key_first_param;
      key_q.second_param <= req_i.key_second_param;
      value_q            <= req_i.entry_value;
    end
    if ((state_q == ST_APPLY) && out_free) begin
      out_value_q <= ((type_q == skvt_pkg::REQ_FIND) && hit) ? chain[CAPACITY].acc : '0;
      out_total_q <= ctrl.insert ? skvt_pkg::TotalW'(count_q + 1'b1) :
                                   skvt_pkg::TotalW'(count_q);
      if (type_q == skvt_pkg::REQ_FIND) begin
        if (hit) begin
          out_status_q <= skvt_pkg::STATUS_FOUND;
        end else begin
          out_status_q <= skvt_pkg::STATUS_NOT_FOUND;
        end
      end else if (hit) begin
        out_status_q <= skvt_pkg::STATUS_REPLACED;
      end else if (full) begin
        out_status_q <= skvt_pkg::STATUS_FULL;
      end else begin
        out_status_q <= skvt_pkg::STATUS_INSERTED;
      end
    end
  end

endmodule
